// ----- hdl/rpia_pkg.sv -----
package rpia_pkg;

    localparam int unsigned FIELD_ID_BITS  = 16;
    localparam int unsigned FIELD_TRY_BITS = 4;
    localparam int unsigned CFG_IDX_BITS   = 2;
    localparam int unsigned CFG_DATA_BITS  = 16;

    localparam logic [FIELD_ID_BITS-1:0]  LFSR_TAPS   = 16'hB400;
    localparam logic [FIELD_ID_BITS-1:0]  SEED_RESET  = 16'd44257;
    localparam logic [FIELD_ID_BITS-1:0]  SEED_FLOOR  = 16'h0001;
    localparam logic [FIELD_TRY_BITS-1:0] TRIES_RESET = 4'd8;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SEED  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIES = 2'd1;

    typedef struct packed {
        logic                     func;
        logic [FIELD_ID_BITS-1:0] release_id;
    } t_in;

    typedef struct packed {
        logic [FIELD_ID_BITS-1:0]  granted_id;
        logic                      gave_up;
        logic [FIELD_TRY_BITS-1:0] tries_used;
    } t_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_TEST,
        S_GRANT
    } t_state;

    typedef struct packed {
        logic clr_we;
        logic free_we;
        logic start;
        logic probe;
        logic grant;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic rd_bit;
        logic tries_done;
        logic out_free;
    } t_status;

    function automatic logic [FIELD_ID_BITS-1:0] lfsr_next(input logic [FIELD_ID_BITS-1:0] s);
        logic [FIELD_ID_BITS-1:0] r;
        r = s >> 1;
        if (s[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

// ----- hdl/rpia_ctrl.sv -----
module rpia_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_func,
    input  rpia_pkg::t_status i_status,
    output logic             o_in_ready,
    output rpia_pkg::t_cmd   o_cmd
);

    rpia_pkg::t_state r_state;
    rpia_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpia_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rpia_pkg::S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = rpia_pkg::S_IDLE;
                end
            end
            rpia_pkg::S_IDLE: begin
                if (i_in_valid && i_func == rpia_pkg::FUNC_ALLOC) begin
                    n_state = rpia_pkg::S_PROBE;
                end
            end
            rpia_pkg::S_PROBE: begin
                n_state = rpia_pkg::S_TEST;
            end
            rpia_pkg::S_TEST: begin
                if (!i_status.rd_bit || i_status.tries_done) begin
                    n_state = rpia_pkg::S_GRANT;
                end else begin
                    n_state = rpia_pkg::S_PROBE;
                end
            end
            rpia_pkg::S_GRANT: begin
                if (i_status.out_free) begin
                    n_state = rpia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rpia_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rpia_pkg::S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
            end
            rpia_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.free_we = i_in_valid && i_func == rpia_pkg::FUNC_FREE;
                o_cmd.start   = i_in_valid && i_func == rpia_pkg::FUNC_ALLOC;
            end
            rpia_pkg::S_PROBE: begin
                o_cmd.probe = 1'b1;
            end
            rpia_pkg::S_TEST: begin
            end
            rpia_pkg::S_GRANT: begin
                o_cmd.grant = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hdl/rpia_dpath.sv -----
module rpia_dpath #(
    parameter int unsigned ID_BITS   = 16,
    parameter int unsigned TRY_LIMIT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rpia_pkg::t_cmd                      i_cmd,
    input  logic [rpia_pkg::FIELD_ID_BITS-1:0]  i_release_id,
    input  logic                                i_cfg_we,
    input  logic [rpia_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [rpia_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output rpia_pkg::t_out                      o_out_data,
    output rpia_pkg::t_status                   o_status
);

    localparam int unsigned DEPTH = 1 << ID_BITS;
    localparam int unsigned LW    = $clog2(TRY_LIMIT + 1);
    localparam logic [4:0]  LIMIT5 = 5'(TRY_LIMIT);
    localparam logic [4:0]  RESET5 = (5'(rpia_pkg::TRIES_RESET) > LIMIT5) ?
                                     LIMIT5 : 5'(rpia_pkg::TRIES_RESET);

    logic                              r_map [DEPTH];
    logic [ID_BITS-1:0]                r_clr_addr;
    logic [rpia_pkg::FIELD_ID_BITS-1:0] r_lfsr;
    logic [rpia_pkg::FIELD_ID_BITS-1:0] n_lfsr;
    logic [LW-1:0]                     r_limit;
    logic [LW-1:0]                     r_tries;
    logic                              r_rd_bit;
    logic                              r_out_valid;
    rpia_pkg::t_out                    r_out_data;

    logic [rpia_pkg::FIELD_ID_BITS-1:0] lfsr_step;
    logic [ID_BITS-1:0]                 wr_addr;
    logic                               wr_bit;
    logic                               wr_en;
    logic [4:0]                         cfg_tries;
    logic [4:0]                         n_limit5;
    logic [4:0]                         tries5;

    assign lfsr_step = rpia_pkg::lfsr_next(r_lfsr);

    always_comb begin
        wr_en   = i_cmd.clr_we || i_cmd.free_we || i_cmd.grant;
        wr_addr = r_lfsr[ID_BITS-1:0];
        wr_bit  = 1'b1;
        if (i_cmd.clr_we) begin
            wr_addr = r_clr_addr;
            wr_bit  = 1'b0;
        end else if (i_cmd.free_we) begin
            wr_addr = i_release_id[ID_BITS-1:0];
            wr_bit  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_bit;
        end
        if (i_cmd.probe) begin
            r_rd_bit <= r_map[lfsr_step[ID_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_comb begin
        n_lfsr = r_lfsr;
        if (i_cfg_we && i_cfg_index == rpia_pkg::CFG_SEED) begin
            n_lfsr = (i_cfg_data == '0) ? rpia_pkg::SEED_FLOOR : i_cfg_data;
        end else if (i_cmd.probe) begin
            n_lfsr = lfsr_step;
        end
    end

    always_comb begin
        cfg_tries = {1'b0, i_cfg_data[rpia_pkg::FIELD_TRY_BITS-1:0]};
        if (cfg_tries == '0) begin
            n_limit5 = 5'd1;
        end else if (cfg_tries > LIMIT5) begin
            n_limit5 = LIMIT5;
        end else begin
            n_limit5 = cfg_tries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr  <= rpia_pkg::SEED_RESET;
            r_limit <= RESET5[LW-1:0];
            r_tries <= '0;
        end else begin
            r_lfsr <= n_lfsr;
            if (i_cfg_we && i_cfg_index == rpia_pkg::CFG_TRIES) begin
                r_limit <= n_limit5[LW-1:0];
            end
            if (i_cmd.start) begin
                r_tries <= '0;
            end else if (i_cmd.probe) begin
                r_tries <= r_tries + 1'b1;
            end
        end
    end

    assign tries5 = 5'(r_tries);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.grant) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grant) begin
            r_out_data.granted_id <= rpia_pkg::FIELD_ID_BITS'(r_lfsr[ID_BITS-1:0]);
            r_out_data.gave_up    <= r_rd_bit;
            r_out_data.tries_used <= tries5[rpia_pkg::FIELD_TRY_BITS-1:0];
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out_data;
    assign o_status.clr_last   = &r_clr_addr;
    assign o_status.rd_bit     = r_rd_bit;
    assign o_status.tries_done = (r_tries == r_limit);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule

// ----- hdl/random_probe_id_allocator.sv -----
// Identifier allocator over a one-bit-per-identifier in-use map held in a
// single-port RAM of 2^ID_BITS entries. After reset the map is swept clear,
// one entry per cycle, across all 2^ID_BITS entries (65536 at the default
// width); no item is accepted during the sweep, configuration writes are.
// A free item clears its map bit and produces no transfer. An allocate item
// draws n candidates (n at most max_tries, clamped to TRY_LIMIT); each steps
// the LFSR and is read from the map into a register in the probe state, then
// tested in the test state. The grant state waits for a free output register,
// then marks the map and loads it; that register lets the next item be
// accepted while a result is still waiting to be taken.
module random_probe_id_allocator #(
    parameter int unsigned ID_BITS   = 16,
    parameter int unsigned TRY_LIMIT = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rpia_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rpia_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rpia_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rpia_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    rpia_pkg::t_cmd    cmd;
    rpia_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    rpia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    rpia_dpath #(
        .ID_BITS   (ID_BITS),
        .TRY_LIMIT (TRY_LIMIT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_release_id (i_in_data.release_id),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .o_status     (status)
    );

endmodule

// ----- tb/sv/random_probe_id_allocator_checker.sv -----
`timescale 1ns / 100ps
module random_probe_id_allocator_checker #(
    parameter int unsigned ID_BITS   = 16,
    parameter int unsigned TRY_LIMIT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  rpia_pkg::t_in                       i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  rpia_pkg::t_out                      i_out_data,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [rpia_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [rpia_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_grants,
    output int                                  o_gave_ups,
    output int                                  o_frees
);

    localparam int unsigned MAP_DEPTH  = 1 << ID_BITS;
    localparam int unsigned REPORT_CAP = 100;

    bit                                  id_busy [MAP_DEPTH];
    logic [rpia_pkg::FIELD_ID_BITS-1:0]  lfsr_q;
    logic [rpia_pkg::FIELD_TRY_BITS-1:0] tries_reg;
    rpia_pkg::t_out                      grant_queue [$];

    function automatic logic [rpia_pkg::FIELD_ID_BITS-1:0] lfsr_step(
        input logic [rpia_pkg::FIELD_ID_BITS-1:0] s
    );
        return {1'b0, s[rpia_pkg::FIELD_ID_BITS-1:1]} ^ (s[0] ? rpia_pkg::LFSR_TAPS : '0);
    endfunction

    function automatic rpia_pkg::t_out predict_grant();
        rpia_pkg::t_out res;
        int unsigned    limit;
        int unsigned    drawn;
        int unsigned    cand;
        bit             hit;
        limit = (tries_reg == 0) ? 1 : ((tries_reg > TRY_LIMIT) ? TRY_LIMIT : tries_reg);
        drawn = 0;
        cand  = 0;
        hit   = 1'b0;
        while (drawn < limit && !hit) begin
            lfsr_q = lfsr_step(lfsr_q);
            cand   = int'(lfsr_q) & (MAP_DEPTH - 1);
            drawn++;
            hit = !id_busy[cand];
        end
        id_busy[cand]  = 1'b1;
        res.granted_id = rpia_pkg::FIELD_ID_BITS'(cand);
        res.gave_up    = !hit;
        res.tries_used = rpia_pkg::FIELD_TRY_BITS'(drawn);
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_CAP) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        rpia_pkg::t_out want;
        if (!i_rst_n) begin
            foreach (id_busy[k]) id_busy[k] = 1'b0;
            lfsr_q    = rpia_pkg::SEED_RESET;
            tries_reg = rpia_pkg::TRIES_RESET;
            grant_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (grant_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_CAP) begin
                        $error("granted_id: expected no transfer, actual %0d",
                               i_out_data.granted_id);
                    end
                end else begin
                    want = grant_queue.pop_front();
                    check_field("granted_id", want.granted_id, i_out_data.granted_id);
                    check_field("gave_up", want.gave_up, i_out_data.gave_up);
                    check_field("tries_used", want.tries_used, i_out_data.tries_used);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rpia_pkg::CFG_SEED: begin
                        lfsr_q = (i_cfg_data == '0) ? rpia_pkg::SEED_FLOOR : i_cfg_data;
                    end
                    rpia_pkg::CFG_TRIES: begin
                        tries_reg = i_cfg_data[rpia_pkg::FIELD_TRY_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.func == rpia_pkg::FUNC_FREE) begin
                    id_busy[int'(i_in_data.release_id) & (MAP_DEPTH - 1)] = 1'b0;
                    o_frees++;
                end else begin
                    want = predict_grant();
                    grant_queue.push_back(want);
                    o_grants++;
                    if (want.gave_up) begin
                        o_gave_ups++;
                    end
                end
            end
        end
        o_pending = grant_queue.size();
    end

endmodule

// ----- tb/sv/tb_random_probe_id_allocator.sv -----
`timescale 1ns / 100ps
module tb_random_probe_id_allocator;

    localparam int unsigned ID_BITS      = 16;
    localparam int unsigned TRY_LIMIT    = 8;
    localparam logic [rpia_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [rpia_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 235;
    localparam int QUIET_PHASE  = 3;
    localparam int HOLD_PHASE   = 5;
    localparam int HOLD_ITEMS   = 40;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_PCT     = 13;
    localparam int DRAIN_CYCLES = 24;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    rpia_pkg::t_in                      in_data;
    logic                               out_valid;
    logic                               out_ready;
    rpia_pkg::t_out                     out_data;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [rpia_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [rpia_pkg::CFG_DATA_BITS-1:0] cfg_data;

    int fail_count;
    int pending;
    int grants;
    int gave_ups;
    int frees;

    bit                                 quiet_run;
    int                                 hold_req;
    int                                 items_sent;
    int                                 cfg_writes;
    logic [rpia_pkg::FIELD_ID_BITS-1:0] granted_pool [$];
    logic [rpia_pkg::FIELD_ID_BITS-1:0] seed_history [$];
    logic [rpia_pkg::FIELD_ID_BITS-1:0] last_freed;

    random_probe_id_allocator #(
        .ID_BITS   (ID_BITS),
        .TRY_LIMIT (TRY_LIMIT)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    random_probe_id_allocator_checker #(
        .ID_BITS   (ID_BITS),
        .TRY_LIMIT (TRY_LIMIT)
    ) chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_grants     (grants),
        .o_gave_ups   (gave_ups),
        .o_frees      (frees)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic send(input logic func, input logic [rpia_pkg::FIELD_ID_BITS-1:0] id);
        rpia_pkg::t_in item;
        item.func       = func;
        item.release_id = id;
        while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [rpia_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [rpia_pkg::CFG_DATA_BITS-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic load_regs(input logic [rpia_pkg::FIELD_ID_BITS-1:0] seed,
                             input logic [rpia_pkg::CFG_DATA_BITS-1:0] tries);
        write_cfg(rpia_pkg::CFG_SEED, seed);
        write_cfg(rpia_pkg::CFG_TRIES, tries);
        cfg_valid <= 1'b0;
        seed_history.push_back(seed);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic free_granted();
        int unsigned pick;
        if (granted_pool.size() == 0) begin
            send(rpia_pkg::FUNC_FREE, rpia_pkg::FIELD_ID_BITS'($urandom));
        end else begin
            pick       = $urandom_range(granted_pool.size() - 1);
            last_freed = granted_pool[pick];
            granted_pool.delete(pick);
            send(rpia_pkg::FUNC_FREE, last_freed);
        end
    endtask

    task automatic random_item();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) begin
            send(rpia_pkg::FUNC_ALLOC, rpia_pkg::FIELD_ID_BITS'($urandom));
        end else if (roll < 85) begin
            free_granted();
        end else if (roll < 93) begin
            send(rpia_pkg::FUNC_FREE, rpia_pkg::FIELD_ID_BITS'($urandom));
        end else begin
            send(rpia_pkg::FUNC_FREE, last_freed);
        end
    endtask

    // receiver: random stalls, plus a counted hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            granted_pool.push_back(out_data.granted_id);
        end
    end

    initial begin
        logic [rpia_pkg::FIELD_ID_BITS-1:0] extreme_seeds [3];
        logic [rpia_pkg::FIELD_ID_BITS-1:0] seed;
        logic [rpia_pkg::CFG_DATA_BITS-1:0] tries;
        int                                 ph;
        int                                 n;
        extreme_seeds = '{16'h0000, 16'h0001, 16'hFFFF};
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        quiet_run  = 1'b0;
        hold_req   = 0;
        items_sent = 0;
        cfg_writes = 0;
        last_freed = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        write_cfg(CFG_SPARE_LO, 16'hFFFF);
        write_cfg(CFG_SPARE_HI, 16'h5A5A);
        load_regs(16'h0000, 16'd0);
        send(rpia_pkg::FUNC_ALLOC, 16'h0000);
        send(rpia_pkg::FUNC_ALLOC, 16'hFFFF);
        send(rpia_pkg::FUNC_FREE, 16'hFFFF);
        send(rpia_pkg::FUNC_FREE, 16'h0000);
        send(rpia_pkg::FUNC_FREE, 16'h0000);
        send(rpia_pkg::FUNC_ALLOC, 16'h1234);
        settle();

        // replay a used seed: early candidates collide
        load_regs(16'h0001, 16'd15);
        send(rpia_pkg::FUNC_ALLOC, 16'h0000);
        settle();
        load_regs(16'h0001, 16'd1);
        send(rpia_pkg::FUNC_ALLOC, 16'h0000);
        settle();
        load_regs(16'hFFFF, 16'd8);
        repeat (8) send(rpia_pkg::FUNC_ALLOC, rpia_pkg::FIELD_ID_BITS'($urandom));
        settle();
        load_regs(16'hFFFF, 16'd8);
        send(rpia_pkg::FUNC_ALLOC, 16'hFFFF);
        send(rpia_pkg::FUNC_FREE, 16'hAAAA);
        send(rpia_pkg::FUNC_FREE, 16'h5555);
        free_granted();
        settle();

        for (ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(3))
                0: seed = extreme_seeds[$urandom_range(2)];
                1: seed = rpia_pkg::FIELD_ID_BITS'($urandom);
                default: seed = seed_history[$urandom_range(seed_history.size() - 1)];
            endcase
            case ($urandom_range(4))
                0: tries = 16'd0;
                1: tries = 16'd1;
                2: tries = 16'd8;
                3: tries = 16'd15;
                default: tries = rpia_pkg::CFG_DATA_BITS'($urandom_range(15));
            endcase
            load_regs(seed, tries);
            quiet_run = (ph == QUIET_PHASE);
            if (ph == HOLD_PHASE) begin
                hold_req = HOLD_CYCLES;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == HOLD_PHASE && n < HOLD_ITEMS) begin
                    send(rpia_pkg::FUNC_ALLOC, rpia_pkg::FIELD_ID_BITS'($urandom));
                end else begin
                    random_item();
                end
            end
            settle();
        end
        quiet_run = 1'b0;

        $display("Sent %0d items and %0d register writes: %0d grants, %0d gave up, %0d frees.",
                 items_sent, cfg_writes, grants, gave_ups, frees);
        $display("Ran %0d seed/limit phases, one with a %0d-cycle receiver hold-off.",
                 PHASES, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("tb_random_probe_id_allocator passed");
        end else begin
            $display("tb_random_probe_id_allocator failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_random_probe_id_allocator failed");
        $finish;
    end

endmodule
